// File: rtl/key_edge_and_mouse_drag_tracker_top_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef KEY_EDGE_AND_MOUSE_DRAG_TRACKER_TOP_MACROS_SVH
`define KEY_EDGE_AND_MOUSE_DRAG_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define KEDT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kedt: same-cycle property violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define KEDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kedt: next-cycle property violated");

`endif

// File: rtl/kedt_pkg.sv
`timescale 1ns / 1ps

package kedt_pkg;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int KEY_W      = 9;
  localparam int COORD_W    = 16;
  localparam int DELTA_W    = 17;
  localparam int TICK_W     = 20;
  localparam int PERIOD_W   = 20;
  localparam int ELAPSED_W  = 32;
  localparam int EVENT_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Default size of the key bitmap
  localparam int KEY_COUNT_DEF = 512;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(10000);
  localparam logic [KEY_W-1:0]    LEFT_RST   = KEY_W'(256);
  localparam logic [KEY_W-1:0]    RIGHT_RST  = KEY_W'(257);

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_POS     = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_KEY_DOWN = 2'd0,
    EV_KEY_UP   = 2'd1,
    EV_DRAG     = 2'd2
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_LEFT   = 2'd1,
    REG_RIGHT  = 2'd2
  } reg_idx_t;

endpackage

// File: rtl/kedt_if.sv
`timescale 1ns / 1ps

// Input item channel
interface kedt_in_if;
  logic                                   valid;
  logic                                   ready;
  kedt_pkg::kind_t                        kind;
  logic        [kedt_pkg::KEY_W-1:0]      key_code;
  logic signed [kedt_pkg::COORD_W-1:0]    pointer_x;
  logic signed [kedt_pkg::COORD_W-1:0]    pointer_y;
  logic        [kedt_pkg::TICK_W-1:0]     tick_us;

  modport source (output valid, kind, key_code, pointer_x, pointer_y, tick_us, input ready);
  modport sink   (input valid, kind, key_code, pointer_x, pointer_y, tick_us, output ready);
endinterface

// Result item channel
interface kedt_out_if;
  logic                                   valid;
  logic                                   ready;
  kedt_pkg::event_t                       event_type;
  logic        [kedt_pkg::KEY_W-1:0]      event_key;
  logic signed [kedt_pkg::DELTA_W-1:0]    drag_dx;
  logic signed [kedt_pkg::DELTA_W-1:0]    drag_dy;

  modport source (output valid, event_type, event_key, drag_dx, drag_dy, input ready);
  modport sink   (input valid, event_type, event_key, drag_dx, drag_dy, output ready);
endinterface

// File: rtl/kedt_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
// A read at the address being written returns the old contents.
module kedt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = kedt_pkg::KEY_COUNT_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/key_edge_and_mouse_drag_tracker_top.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register, and any result goes on to the result register.
// Throughput: one item per cycle unless busy or stalled; RAM read at accept, written on advance.
// Reset: synchronous, active low; registers return to their defaults, then the bitmap is
// cleared one entry a cycle, and in_ch.ready stays low until the sweep reaches the last entry.
// A write of a button code register holds in_ch.ready low through RF_LEFT, RF_RIGHT and RF_LAST
// while the held state of both buttons is read back from the bitmap.
module key_edge_and_mouse_drag_tracker_top #(
  parameter int KEY_COUNT = kedt_pkg::KEY_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  kedt_in_if.sink                           in_ch,
  kedt_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [kedt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kedt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_COUNT - 1);
  localparam int KEY_W   = kedt_pkg::KEY_W;
  localparam int COORD_W = kedt_pkg::COORD_W;
  localparam int DELTA_W = kedt_pkg::DELTA_W;
  localparam int EL_W    = kedt_pkg::ELAPSED_W;

  typedef enum logic [1:0] {
    RF_IDLE,
    RF_LEFT,
    RF_RIGHT,
    RF_LAST
  } rf_state_t;

  // Configuration registers
  logic [kedt_pkg::PERIOD_W-1:0] period_r;
  logic [KEY_W-1:0]              left_code_r;
  logic [KEY_W-1:0]              right_code_r;

  // Bitmap clear sweep and button refresh
  logic          clear_busy_r;
  logic [AW-1:0] clear_addr_r;
  rf_state_t     rf_state_r;
  logic          rf_go;
  logic          left_held_r;
  logic          right_held_r;
  logic          busy;

  // Input stage
  logic                      in_fire;
  logic                      s1_valid_r;
  logic                      s1_adv;
  kedt_pkg::kind_t           s1_kind_r;
  logic [KEY_W-1:0]          s1_key_r;
  logic signed [COORD_W-1:0] s1_x_r;
  logic signed [COORD_W-1:0] s1_y_r;
  logic [kedt_pkg::TICK_W-1:0] s1_tick_r;

  // RAM ports and write forwarding
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;
  logic          last_wr_valid_r;
  logic [AW-1:0] last_wr_addr_r;
  logic          last_wr_val_r;

  // Tracker state
  logic signed [COORD_W-1:0] cursor_x_r;
  logic signed [COORD_W-1:0] cursor_y_r;
  logic                      dragging_r;
  logic [KEY_W-1:0]          drag_button_r;
  logic signed [COORD_W-1:0] origin_x_r;
  logic signed [COORD_W-1:0] origin_y_r;
  logic [EL_W-1:0]           elapsed_r;

  // Item evaluation
  logic          s1_in_range;
  logic [AW-1:0] s1_addr;
  logic          was_down;
  logic          key_wr;
  logic          key_res;
  logic          start_l, stop_l, start_r, stop_r;
  logic          drag1, drag_nxt;
  logic [KEY_W-1:0] btn1, btn_nxt;
  logic          restart;
  logic [EL_W-1:0]  base_el;
  logic [EL_W:0]    sum_el;
  logic [EL_W-1:0]  sat_el;
  logic          over;
  logic          drag_res;
  logic [EL_W-1:0]  elapsed_nxt;
  logic signed [COORD_W-1:0] org_x, org_y;
  logic signed [DELTA_W-1:0] dx, dy;
  logic          res_valid;
  kedt_pkg::event_t res_type;
  logic [KEY_W-1:0] res_key;
  logic signed [DELTA_W-1:0] res_dx, res_dy;

  // Result register
  logic                      out_valid_r;
  kedt_pkg::event_t          out_type_r;
  logic [KEY_W-1:0]          out_key_r;
  logic signed [DELTA_W-1:0] out_dx_r;
  logic signed [DELTA_W-1:0] out_dy_r;

  function automatic logic in_range(input logic [KEY_W-1:0] code);
    return 32'(code) < 32'(KEY_COUNT);
  endfunction

  // Take the newest write to this address over the RAM contents
  function automatic logic fwd(input logic [AW-1:0] addr, input logic rd,
                               input logic lv, input logic [AW-1:0] la,
                               input logic lval);
    return (lv && la == addr) ? lval : rd;
  endfunction

  // Handshake
  assign busy        = clear_busy_r || (rf_state_r != RF_IDLE);
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !busy && (!s1_valid_r || s1_adv);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rf_go       = (rf_state_r == RF_LEFT) && !clear_busy_r && !s1_valid_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= kedt_pkg::PERIOD_RST;
      left_code_r  <= kedt_pkg::LEFT_RST;
      right_code_r <= kedt_pkg::RIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kedt_pkg::REG_PERIOD: period_r     <= cfg_wdata[kedt_pkg::PERIOD_W-1:0];
        kedt_pkg::REG_LEFT:   left_code_r  <= cfg_wdata[KEY_W-1:0];
        kedt_pkg::REG_RIGHT:  right_code_r <= cfg_wdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Clear the bitmap after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clear_addr_r <= '0;
    end else if (clear_busy_r) begin
      clear_addr_r <= clear_addr_r + AW'(1);
      if (clear_addr_r == LAST_ADDR) begin
        clear_busy_r <= 1'b0;
      end
    end
  end

  // RAM port selection
  assign s1_in_range = in_range(s1_key_r);
  assign s1_addr     = AW'(s1_key_r);
  assign key_wr      = s1_adv && s1_in_range &&
                       (s1_kind_r == kedt_pkg::KIND_PRESS ||
                        s1_kind_r == kedt_pkg::KIND_RELEASE);
  assign ram_we      = clear_busy_r || key_wr;
  assign ram_waddr   = clear_busy_r ? clear_addr_r : s1_addr;
  assign ram_wdata   = !clear_busy_r && (s1_kind_r == kedt_pkg::KIND_PRESS);
  assign ram_re      = in_fire || rf_go || (rf_state_r == RF_RIGHT);
  assign ram_raddr   = (rf_state_r == RF_LEFT)  ? AW'(left_code_r)  :
                       (rf_state_r == RF_RIGHT) ? AW'(right_code_r) :
                                                  AW'(in_ch.key_code);

  kedt_ram #(
    .WIDTH (1),
    .DEPTH (KEY_COUNT)
  ) u_key_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Remember the last key write for read-after-write forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_wr_valid_r <= 1'b0;
    end else if (key_wr) begin
      last_wr_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      last_wr_addr_r <= s1_addr;
      last_wr_val_r  <= ram_wdata;
    end
  end

  // Button refresh state machine and held-button shadows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_state_r   <= RF_IDLE;
      left_held_r  <= 1'b0;
      right_held_r <= 1'b0;
    end else begin
      unique case (rf_state_r)
        RF_IDLE:  rf_state_r <= RF_IDLE;
        RF_LEFT:  if (rf_go) rf_state_r <= RF_RIGHT;
        RF_RIGHT: rf_state_r <= RF_LAST;
        RF_LAST:  rf_state_r <= RF_IDLE;
        default:  rf_state_r <= RF_IDLE;
      endcase
      if (cfg_we && (cfg_index == kedt_pkg::REG_LEFT ||
                     cfg_index == kedt_pkg::REG_RIGHT)) begin
        rf_state_r <= RF_LEFT;
      end

      // Capture read-back data, then let a concurrent key write win
      if (rf_state_r == RF_RIGHT) begin
        left_held_r <= in_range(left_code_r) &&
                       fwd(AW'(left_code_r), ram_rdata, last_wr_valid_r,
                           last_wr_addr_r, last_wr_val_r);
      end
      if (rf_state_r == RF_LAST) begin
        right_held_r <= in_range(right_code_r) &&
                        fwd(AW'(right_code_r), ram_rdata, last_wr_valid_r,
                            last_wr_addr_r, last_wr_val_r);
      end
      if (key_wr && s1_key_r == left_code_r) begin
        left_held_r <= ram_wdata;
      end
      if (key_wr && s1_key_r == right_code_r) begin
        right_held_r <= ram_wdata;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_ch.kind;
      s1_key_r  <= in_ch.key_code;
      s1_x_r    <= in_ch.pointer_x;
      s1_y_r    <= in_ch.pointer_y;
      s1_tick_r <= in_ch.tick_us;
    end
  end

  // Key edge detect
  assign was_down = fwd(s1_addr, ram_rdata, last_wr_valid_r, last_wr_addr_r, last_wr_val_r);
  assign key_res  = s1_in_range &&
                    ((s1_kind_r == kedt_pkg::KIND_PRESS   && !was_down) ||
                     (s1_kind_r == kedt_pkg::KIND_RELEASE &&  was_down));

  // Button checks: left first, then right
  assign start_l = left_held_r && (!dragging_r || drag_button_r != left_code_r);
  assign stop_l  = !left_held_r && dragging_r && drag_button_r == left_code_r;
  assign drag1   = start_l || (dragging_r && !stop_l);
  assign btn1    = start_l ? left_code_r : drag_button_r;
  assign start_r = right_held_r && (!drag1 || btn1 != right_code_r);
  assign stop_r  = !right_held_r && drag1 && btn1 == right_code_r;
  assign drag_nxt = start_r || (drag1 && !stop_r);
  assign btn_nxt  = start_r ? right_code_r : btn1;
  assign restart  = start_l || start_r;

  // Elapsed time: saturating add, compare, subtract one period
  assign base_el  = restart ? '0 : elapsed_r;
  assign sum_el   = {1'b0, base_el} + (EL_W + 1)'(s1_tick_r);
  assign sat_el   = sum_el[EL_W] ? '1 : sum_el[EL_W-1:0];
  assign over     = sat_el > EL_W'(period_r);
  assign drag_res = drag_nxt && over;
  assign elapsed_nxt = !drag_nxt ? base_el :
                       drag_res  ? sat_el - EL_W'(period_r) : sat_el;

  // Movement since the drag origin
  assign org_x = restart ? cursor_x_r : origin_x_r;
  assign org_y = restart ? cursor_y_r : origin_y_r;
  assign dx    = DELTA_W'(cursor_x_r) - DELTA_W'(org_x);
  assign dy    = DELTA_W'(cursor_y_r) - DELTA_W'(org_y);

  // Select the result for the item in the input register
  always_comb begin
    res_valid = 1'b0;
    res_type  = kedt_pkg::EV_KEY_DOWN;
    res_key   = s1_key_r;
    res_dx    = '0;
    res_dy    = '0;
    unique case (s1_kind_r)
      kedt_pkg::KIND_PRESS: begin
        res_valid = key_res;
      end
      kedt_pkg::KIND_RELEASE: begin
        res_valid = key_res;
        res_type  = kedt_pkg::EV_KEY_UP;
      end
      kedt_pkg::KIND_POS: begin
        res_valid = 1'b0;
      end
      kedt_pkg::KIND_TICK: begin
        res_valid = drag_res;
        res_type  = kedt_pkg::EV_DRAG;
        res_key   = btn_nxt;
        res_dx    = dx;
        res_dy    = dy;
      end
      default: res_valid = 1'b0;
    endcase
  end

  // Update cursor and drag state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r    <= '0;
      cursor_y_r    <= '0;
      dragging_r    <= 1'b0;
      drag_button_r <= '0;
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      elapsed_r     <= '0;
    end else if (s1_adv) begin
      if (s1_kind_r == kedt_pkg::KIND_POS) begin
        cursor_x_r <= s1_x_r;
        cursor_y_r <= s1_y_r;
      end
      if (s1_kind_r == kedt_pkg::KIND_TICK) begin
        dragging_r    <= drag_nxt;
        drag_button_r <= btn_nxt;
        elapsed_r     <= elapsed_nxt;
        if (restart || drag_res) begin
          origin_x_r <= cursor_x_r;
          origin_y_r <= cursor_y_r;
        end
      end
    end
  end

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_type_r <= res_type;
      out_key_r  <= res_key;
      out_dx_r   <= res_dx;
      out_dy_r   <= res_dy;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_type = out_type_r;
  assign out_ch.event_key  = out_key_r;
  assign out_ch.drag_dx    = out_dx_r;
  assign out_ch.drag_dy    = out_dy_r;

endmodule

// File: rtl/kedt_checker.sv
`timescale 1ns / 1ps
`include "key_edge_and_mouse_drag_tracker_top_macros.svh"

module kedt_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input kedt_pkg::event_t                     out_event_type,
  input logic        [kedt_pkg::KEY_W-1:0]    out_event_key,
  input logic signed [kedt_pkg::DELTA_W-1:0]  out_drag_dx,
  input logic signed [kedt_pkg::DELTA_W-1:0]  out_drag_dy,
  input logic                                 cfg_we,
  input logic        [kedt_pkg::CFG_IDX_W-1:0] cfg_index
);

  // Bitmap clear blocks input right after reset
  `KEDT_ASSERT_IMPL(a_clear_after_reset, $past(!rst_n), !in_ready)

  // Button code write blocks input while the held state is read back
  `KEDT_ASSERT_NEXT(a_refresh_stall, cfg_we && (cfg_index == kedt_pkg::REG_LEFT || cfg_index == kedt_pkg::REG_RIGHT), !in_ready)

  // Key results carry no movement
  `KEDT_ASSERT_IMPL(a_key_zero_delta, out_valid && out_event_type != kedt_pkg::EV_DRAG, out_drag_dx == 0 && out_drag_dy == 0)

  // Stalled result holds
  `KEDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_type) && $stable(out_event_key) && $stable(out_drag_dx) && $stable(out_drag_dy))

endmodule

bind key_edge_and_mouse_drag_tracker_top kedt_checker u_kedt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_event_type (out_ch.event_type),
  .out_event_key  (out_ch.event_key),
  .out_drag_dx    (out_ch.drag_dx),
  .out_drag_dy    (out_ch.drag_dy),
  .cfg_we         (cfg_we),
  .cfg_index      (cfg_index)
);
